/* design/e2f_pkg.sv */
package e2f_pkg;

    localparam int unsigned SEC_W   = 32;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned YOFF_W  = 7;
    localparam int unsigned YEAR_W  = 11;
    localparam int unsigned DAYS_W  = 16;

    localparam logic [YEAR_W-1:0] BASE_YEAR  = 11'd1980;
    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 11'd1970;
    // 1970 mod 100 and mod 400
    localparam logic [6:0]        EPOCH_C100 = 7'd70;
    localparam logic [8:0]        EPOCH_C400 = 9'd370;
    localparam logic [6:0]        C100_LAST  = 7'd99;
    localparam logic [8:0]        C400_LAST  = 9'd399;

    localparam logic [8:0] DAYS_YEAR     = 9'd365;
    localparam logic [8:0] DAYS_LEAP     = 9'd366;
    localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;
    localparam logic [3:0] MONTH_FEB     = 4'd1;
    localparam logic [3:0] MONTH_DEC     = 4'd11;

    localparam logic [YOFF_W-1:0] FALLBACK_RESET = 7'd46;

    // Division steps: seconds, minutes, hours
    localparam logic [1:0] DIV_SEC  = 2'd0;
    localparam logic [1:0] DIV_MIN  = 2'd1;
    localparam logic [1:0] DIV_HOUR = 2'd2;

    // Reciprocals: n / 60 == (n * MAG60) >> 37 for any 32-bit n,
    // n / 24 == (n * MAG24) >> 26 for n below 2^21.
    localparam logic [31:0] MAG60   = 32'h8888_8889;
    localparam int unsigned SHIFT60 = 37;
    localparam logic [31:0] MAG24   = 32'd2796203;
    localparam int unsigned SHIFT24 = 26;
    localparam logic [31:0] DIVISOR60 = 32'd60;
    localparam logic [31:0] DIVISOR24 = 32'd24;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        if (m > MONTH_DEC)
            d = MONTH_LEN[11];
        else if (m == MONTH_FEB && leap)
            d = DAYS_FEB_LEAP;
        else
            d = MONTH_LEN[m];
        return d;
    endfunction

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_SPLIT = 6'b000100,
        ST_YEAR  = 6'b001000,
        ST_MONTH = 6'b010000,
        ST_DONE  = 6'b100000
    } e2f_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic split;
        logic year_step;
        logic month_step;
        logic emit;
    } e2f_cmd_t;

    typedef struct packed {
        logic in_zero;
        logic div_last;
        logic year_done;
        logic month_done;
    } e2f_status_t;

endpackage

/* design/e2f_if.sv */
interface e2f_in_if;
    logic                         valid;
    logic                         ready;
    logic [e2f_pkg::SEC_W-1:0]    epoch_seconds;

    modport source(output valid, output epoch_seconds, input ready);
    modport sink(input valid, input epoch_seconds, output ready);
endinterface

interface e2f_out_if;
    logic                         valid;
    logic                         ready;
    logic [e2f_pkg::WORD_W-1:0]   fat_timestamp;

    modport source(output valid, output fat_timestamp, input ready);
    modport sink(input valid, input fat_timestamp, output ready);
endinterface

/* design/e2f_datapath.sv */
module e2f_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [e2f_pkg::YOFF_W-1:0]    cfg_wdata,
    input  logic [e2f_pkg::SEC_W-1:0]     epoch_seconds,
    input  e2f_pkg::e2f_cmd_t             cmd,
    output e2f_pkg::e2f_status_t          status,
    output logic [e2f_pkg::WORD_W-1:0]    fat_timestamp
);

    logic [e2f_pkg::YOFF_W-1:0] fallback_reg;
    logic [31:0]                x_reg;
    logic [63:0]                prod_reg;
    logic [1:0]                 idx_reg;
    logic                       zero_reg;
    logic [5:0]                 sec_reg;
    logic [5:0]                 min_reg;
    logic [4:0]                 hr_reg;
    logic [e2f_pkg::DAYS_W-1:0] days_reg;
    logic [e2f_pkg::YEAR_W-1:0] yr_reg;
    logic [6:0]                 c100_reg;
    logic [8:0]                 c400_reg;
    logic [3:0]                 m_reg;
    logic [e2f_pkg::WORD_W-1:0] word_reg;

    logic [31:0]                magic;
    logic [63:0]                q_full;
    logic [31:0]                q;
    logic [31:0]                rem;
    logic                       leap;
    logic [8:0]                 diy;
    logic [4:0]                 dim;
    logic [e2f_pkg::YEAR_W-1:0] yr_off;
    logic [e2f_pkg::WORD_W-1:0] word_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fallback_reg <= e2f_pkg::FALLBACK_RESET;
        else if (cfg_we)
            fallback_reg <= cfg_wdata;
    end

    always_comb
    begin
        if (idx_reg == e2f_pkg::DIV_HOUR)
        begin
            magic  = e2f_pkg::MAG24;
            q_full = prod_reg >> e2f_pkg::SHIFT24;
            rem    = x_reg - q_full[31:0] * e2f_pkg::DIVISOR24;
        end
        else
        begin
            magic  = e2f_pkg::MAG60;
            q_full = prod_reg >> e2f_pkg::SHIFT60;
            rem    = x_reg - q_full[31:0] * e2f_pkg::DIVISOR60;
        end
        q = q_full[31:0];
    end

    // Gregorian leap rule from the running mod-100 and mod-400 counters
    assign leap = (yr_reg[1:0] == 2'd0 && c100_reg != 7'd0) || c400_reg == 9'd0;
    assign diy  = leap ? e2f_pkg::DAYS_LEAP : e2f_pkg::DAYS_YEAR;
    assign dim  = e2f_pkg::month_days(m_reg, leap);

    assign status.in_zero    = (epoch_seconds == '0);
    assign status.div_last   = (idx_reg == e2f_pkg::DIV_HOUR);
    assign status.year_done  = (days_reg < e2f_pkg::DAYS_W'(diy));
    assign status.month_done = (days_reg < e2f_pkg::DAYS_W'(dim)) ||
                               (m_reg == e2f_pkg::MONTH_DEC);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= epoch_seconds;
            zero_reg <= (epoch_seconds == '0);
            idx_reg  <= e2f_pkg::DIV_SEC;
            yr_reg   <= e2f_pkg::EPOCH_YEAR;
            c100_reg <= e2f_pkg::EPOCH_C100;
            c400_reg <= e2f_pkg::EPOCH_C400;
            m_reg    <= 4'd0;
        end
        if (cmd.mul)
            prod_reg <= 64'(x_reg) * 64'(magic);
        if (cmd.split)
        begin
            x_reg   <= q;
            idx_reg <= idx_reg + 2'd1;
            case (idx_reg)
                e2f_pkg::DIV_SEC:  sec_reg <= rem[5:0];
                e2f_pkg::DIV_MIN:  min_reg <= rem[5:0];
                default:
                begin
                    hr_reg   <= rem[4:0];
                    days_reg <= q[e2f_pkg::DAYS_W-1:0];
                end
            endcase
        end
        if (cmd.year_step)
        begin
            days_reg <= days_reg - e2f_pkg::DAYS_W'(diy);
            yr_reg   <= yr_reg + 11'd1;
            c100_reg <= (c100_reg == e2f_pkg::C100_LAST) ? 7'd0 : c100_reg + 7'd1;
            c400_reg <= (c400_reg == e2f_pkg::C400_LAST) ? 9'd0 : c400_reg + 9'd1;
        end
        if (cmd.month_step)
        begin
            days_reg <= days_reg - e2f_pkg::DAYS_W'(dim);
            m_reg    <= m_reg + 4'd1;
        end
        if (cmd.emit)
            word_reg <= word_next;
    end

    assign yr_off = yr_reg - e2f_pkg::BASE_YEAR;

    always_comb
    begin
        if (zero_reg)
            word_next = {fallback_reg, 4'd1, 5'd1, 16'd0};
        else
            word_next = {yr_off[6:0], m_reg + 4'd1, days_reg[4:0] + 5'd1,
                         hr_reg, min_reg, sec_reg[5:1]};
    end

    assign fat_timestamp = word_reg;

endmodule

/* design/e2f_ctrl.sv */
module e2f_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  e2f_pkg::e2f_status_t  status,
    output e2f_pkg::e2f_cmd_t     cmd
);

    e2f_pkg::e2f_state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            e2f_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.in_zero ? e2f_pkg::ST_DONE : e2f_pkg::ST_MUL;
                end
            end
            e2f_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = e2f_pkg::ST_SPLIT;
            end
            e2f_pkg::ST_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = status.div_last ? e2f_pkg::ST_YEAR : e2f_pkg::ST_MUL;
            end
            e2f_pkg::ST_YEAR:
            begin
                if (status.year_done)
                    state_next = e2f_pkg::ST_MONTH;
                else
                    cmd.year_step = 1'b1;
            end
            e2f_pkg::ST_MONTH:
            begin
                if (status.month_done)
                    state_next = e2f_pkg::ST_DONE;
                else
                    cmd.month_step = 1'b1;
            end
            e2f_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = e2f_pkg::ST_IDLE;
                end
            end
            default:
                state_next = e2f_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= e2f_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_zero_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == e2f_pkg::ST_IDLE && in_valid && status.in_zero)
        |=> state_reg == e2f_pkg::ST_DONE)
        else $error("zero input did not go straight to done");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten before it was taken");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted word not presented");

    a_year_to_month: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == e2f_pkg::ST_YEAR && status.year_done)
        |=> state_reg == e2f_pkg::ST_MONTH)
        else $error("year walk did not hand over to month walk");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");
`endif

endmodule

/* design/epoch_to_fat_timestamp.sv */
// Converts seconds since 1970-01-01 into a packed FAT date/time word, one word
// at a time. A word is accepted, then passes through the three
// divide-by-constant steps (one shared reciprocal multiplier, multiply then
// split), the year walk, which steps once per whole year since 1970, the month
// walk and the load of the output register, plus any wait for the previous word
// to be taken. A zero count skips the arithmetic and yields the fallback year,
// January 1, 00:00:00.
// The user must write the fallback year offset through cfg_we/cfg_wdata only
// while idle; the block itself does not enforce this.
module epoch_to_fat_timestamp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [e2f_pkg::YOFF_W-1:0]    cfg_wdata,
    e2f_in_if.sink                        req,
    e2f_out_if.source                     rsp
);

    e2f_pkg::e2f_cmd_t    cmd;
    e2f_pkg::e2f_status_t status;

    e2f_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    e2f_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .epoch_seconds (req.epoch_seconds),
        .cmd           (cmd),
        .status        (status),
        .fat_timestamp (rsp.fat_timestamp)
    );

endmodule
